/* sv/delta_list_timer_queue_macros.svh */
// Assertion macros for the delta-list timer queue checker.
// Expect signals named clk and rst_n in the scope of use.
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication
`define DLTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DLTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dltq_pkg.sv */
// Shared types and constants of the delta-list timer queue.
// No dependencies; used by every module of the block.
package dltq_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int IX_W        = $clog2(ENTRY_COUNT);
  localparam int IDX_W       = $clog2(ENTRY_COUNT + 1);
  localparam int CNT_W       = 7;

  localparam logic [IDX_W-1:0] NIL          = IDX_W'(ENTRY_COUNT);
  localparam logic [CNT_W-1:0] FULL_POOL    = CNT_W'(ENTRY_COUNT);
  localparam logic [7:0]       HOLD_OFF_RST = 8'd2;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_DEFER  = 2'd1;
  localparam logic [1:0] OP_ASAP   = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_POOL = 2'd1;
  localparam logic [1:0] ERR_ASAP = 2'd2;

  // command classes made by the front end
  localparam logic [2:0] CL_TICK     = 3'd0;
  localparam logic [2:0] CL_CANCEL   = 3'd1;
  localparam logic [2:0] CL_IGNORE   = 3'd2;
  localparam logic [2:0] CL_ERR_ASAP = 3'd3;
  localparam logic [2:0] CL_IMM      = 3'd4;
  localparam logic [2:0] CL_SCHED    = 3'd5;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         action_id;
    logic signed [31:0] delay;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       fired_action;
    logic             run_now;
    logic             overdue;
    logic [1:0]       error_code;
    logic [CNT_W-1:0] free_entries;
    logic [CNT_W-1:0] min_free_entries;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  act;
    logic        asap;
    logic [31:0] delay;
  } cmd_t;

endpackage

/* sv/dltq_front.sv */
// Front end: accepts input words, classifies them and queues commands.
// Depends on dltq_pkg.
module dltq_front import dltq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  output cmd_t     cmd,
  input  logic     cmd_pop,
  output logic     cmd_valid
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cls_cmd;
  logic       push;

  always_comb begin
    cls_cmd.act   = in_word.action_id;
    cls_cmd.asap  = (in_word.operation == OP_ASAP);
    cls_cmd.delay = in_word.delay;
    if (in_word.operation == OP_TICK) begin
      cls_cmd.cls = CL_TICK;
    end else if (in_word.operation == OP_CANCEL) begin
      cls_cmd.cls = (in_word.action_id == 8'd0) ? CL_IGNORE : CL_CANCEL;
    end else if (in_word.operation == OP_ASAP && in_word.delay == 32'sd0) begin
      cls_cmd.cls = CL_ERR_ASAP;
    end else if (in_word.action_id == 8'd0) begin
      cls_cmd.cls = CL_IGNORE;
    end else if (in_word.delay == 32'sd0 || in_word.delay[31]) begin
      cls_cmd.cls = CL_IMM;
    end else begin
      cls_cmd.cls = CL_SCHED;
    end
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

/* sv/dltq_back.sv */
// Back end: list sequencer, entry store, free pool and result register.
// Depends on dltq_pkg.
module dltq_back import dltq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RM   = 3'd1;
  localparam logic [2:0] S_INI  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_PLC  = 3'd4;
  localparam logic [2:0] S_EXP  = 3'd5;
  localparam logic [2:0] S_IMM  = 3'd6;
  localparam logic [2:0] S_ACK  = 3'd7;

  logic [7:0]       act_r  [ENTRY_COUNT];
  logic [31:0]      dlt_r  [ENTRY_COUNT];
  logic             asap_r [ENTRY_COUNT];
  logic [IDX_W-1:0] lnk_r  [ENTRY_COUNT];

  logic [IDX_W-1:0] head_r, fhead_r, cur_r, prev_r, new_r, n_r;
  logic [CNT_W-1:0] fcnt_r, flow_r;
  logic [31:0]      elap_r;
  logic [7:0]       mind_r;
  logic [2:0]       state_r;
  cmd_t             cmd_r;
  logic [1:0]       err_r;
  logic             ret_ins_r;
  logic [39:0]      target_r, acc_r;
  logic             out_valid_r;
  out_word_t        out_r;

  logic [IX_W-1:0]  cur_ix, prev_ix, hd_ix, fh_ix, new_ix, nx_ix;
  logic             slot_free, cur_ok;
  logic [31:0]      elap_inc;
  logic             tick_due;
  logic [33:0]      e_s, d_s, m_s, ed_diff;
  logic             keep_wait, late;
  logic [39:0]      nabs, dd;
  logic             go_on;
  logic [31:0]      d32, load, loadm;
  logic [IDX_W-1:0] nx;
  logic [CNT_W-1:0] fcnt_dec;

  assign cur_ix  = cur_r[IX_W-1:0];
  assign prev_ix = prev_r[IX_W-1:0];
  assign hd_ix   = head_r[IX_W-1:0];
  assign fh_ix   = fhead_r[IX_W-1:0];
  assign new_ix  = new_r[IX_W-1:0];
  assign nx      = lnk_r[cur_ix];
  assign nx_ix   = nx[IX_W-1:0];

  assign slot_free = !out_valid_r || !out_stall;
  assign cur_ok    = (cur_r != NIL) && (n_r != NIL);
  assign elap_inc  = elap_r + 32'd1;
  assign tick_due  = (head_r != NIL) &&
                     !($signed({elap_inc[31], elap_inc}) < $signed({1'b0, dlt_r[hd_ix]}));

  // expiry arithmetic, 34-bit signed
  assign e_s       = {{2{elap_r[31]}}, elap_r};
  assign d_s       = {2'b00, dlt_r[hd_ix]};
  assign m_s       = {26'd0, mind_r};
  assign keep_wait = $signed(e_s + m_s) < $signed(d_s);
  assign late      = $signed(e_s) > $signed(d_s);
  assign ed_diff   = e_s - d_s;

  // insertion walk, 40-bit signed running sum
  assign nabs  = acc_r + {8'd0, dlt_r[cur_ix]};
  assign go_on = cur_ok && !($signed(nabs) > $signed(target_r));
  assign dd    = target_r - acc_r;
  assign d32   = dd[31:0];
  assign load  = d32 - elap_r;
  assign loadm = (load < {24'd0, mind_r}) ? {24'd0, mind_r} : load;

  assign fcnt_dec = fcnt_r - CNT_W'(1);

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        lnk_r[i] <= IDX_W'(i + 1);
      end
      head_r      <= NIL;
      fhead_r     <= '0;
      fcnt_r      <= FULL_POOL;
      flow_r      <= FULL_POOL;
      elap_r      <= '0;
      mind_r      <= HOLD_OFF_RST;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mind_r <= cfg_wdata;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r     <= cmd;
            err_r     <= ERR_NONE;
            ret_ins_r <= 1'b0;
            prev_r    <= NIL;
            cur_r     <= head_r;
            n_r       <= '0;
            case (cmd.cls)
              CL_TICK: begin
                elap_r  <= elap_inc;
                state_r <= tick_due ? S_EXP : S_ACK;
              end
              CL_CANCEL:   state_r <= S_RM;
              CL_ERR_ASAP: begin
                err_r   <= ERR_ASAP;
                state_r <= S_ACK;
              end
              CL_IMM:      state_r <= S_IMM;
              CL_SCHED: begin
                if (fhead_r == NIL) begin
                  err_r   <= ERR_POOL;
                  state_r <= S_ACK;
                end else begin
                  // take the free head
                  new_r         <= fhead_r;
                  fhead_r       <= lnk_r[fh_ix];
                  lnk_r[fh_ix]  <= NIL;
                  act_r[fh_ix]  <= cmd.act;
                  asap_r[fh_ix] <= cmd.asap;
                  fcnt_r        <= fcnt_dec;
                  if (fcnt_dec < flow_r) flow_r <= fcnt_dec;
                  ret_ins_r     <= 1'b1;
                  state_r       <= S_RM;
                end
              end
              default:     state_r <= S_ACK;
            endcase
          end
        end

        S_RM: begin
          if (!cur_ok) begin
            state_r <= ret_ins_r ? S_INI : S_ACK;
          end else if (act_r[cur_ix] == cmd_r.act) begin
            if (prev_r == NIL) head_r <= nx;
            else lnk_r[prev_ix] <= nx;
            if (nx != NIL) dlt_r[nx_ix] <= dlt_r[nx_ix] + dlt_r[cur_ix];
            lnk_r[cur_ix] <= fhead_r;
            fhead_r       <= cur_r;
            fcnt_r        <= fcnt_r + CNT_W'(1);
            state_r       <= ret_ins_r ? S_INI : S_ACK;
          end else begin
            prev_r <= cur_r;
            cur_r  <= nx;
            n_r    <= n_r + IDX_W'(1);
          end
        end

        S_INI: begin
          target_r <= {8'd0, cmd_r.delay} + {{8{elap_r[31]}}, elap_r};
          acc_r    <= '0;
          prev_r   <= NIL;
          cur_r    <= head_r;
          n_r      <= '0;
          state_r  <= S_INS;
        end

        S_INS: begin
          if (go_on) begin
            acc_r  <= nabs;
            prev_r <= cur_r;
            cur_r  <= nx;
            n_r    <= n_r + IDX_W'(1);
          end else begin
            state_r <= S_PLC;
          end
        end

        S_PLC: begin
          lnk_r[new_ix] <= cur_r;
          if (cur_r != NIL) dlt_r[cur_ix] <= dlt_r[cur_ix] - d32;
          if (prev_r == NIL) begin
            // new head: reload the timer
            dlt_r[new_ix] <= loadm;
            head_r        <= new_r;
            elap_r        <= '0;
          end else begin
            dlt_r[new_ix]  <= d32;
            lnk_r[prev_ix] <= new_r;
          end
          state_r <= S_ACK;
        end

        S_EXP: begin
          if (head_r == NIL || n_r == NIL) begin
            state_r <= S_ACK;
          end else if (keep_wait) begin
            dlt_r[hd_ix] <= 32'(d_s - e_s);
            elap_r       <= '0;
            state_r      <= S_ACK;
          end else if (slot_free) begin
            elap_r       <= ed_diff[31:0];
            head_r       <= lnk_r[hd_ix];
            lnk_r[hd_ix] <= fhead_r;
            fhead_r      <= head_r;
            fcnt_r       <= fcnt_r + CNT_W'(1);
            n_r          <= n_r + IDX_W'(1);
            out_valid_r  <= 1'b1;
            out_r        <= '{kind: KIND_FIRE, fired_action: act_r[hd_ix],
                              run_now: asap_r[hd_ix], overdue: late,
                              error_code: ERR_NONE,
                              free_entries: fcnt_r + CNT_W'(1),
                              min_free_entries: flow_r, last: 1'b0};
          end
        end

        S_IMM: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_r       <= '{kind: KIND_FIRE, fired_action: cmd_r.act,
                             run_now: cmd_r.asap, overdue: 1'b0,
                             error_code: ERR_NONE, free_entries: fcnt_r,
                             min_free_entries: flow_r, last: 1'b0};
            state_r     <= S_ACK;
          end
        end

        S_ACK: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_r       <= '{kind: (err_r != ERR_NONE) ? KIND_ERR : KIND_ACK,
                             fired_action: 8'd0, run_now: 1'b0, overdue: 1'b0,
                             error_code: err_r, free_entries: fcnt_r,
                             min_free_entries: flow_r, last: 1'b1};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/delta_list_timer_queue.sv */
// Delta-list timer queue. Words enter through a two-deep command queue and a
// sequencer works through them one at a time, touching one list entry per
// cycle. A tick that expires nothing goes straight to its acknowledge; an
// expiry checks the head entries one by one; a deferred or asap schedule
// walks the list twice (duplicate removal, then the ordered insert); a cancel
// walks it once. Each result passes through the output register, and a
// stalled output holds the sequencer. Every input word gives its fires, then
// one acknowledge or error word with last set. The link store and pool are
// reset in flops: no clearing pass.
// Depends on dltq_pkg, dltq_front and dltq_back.
module delta_list_timer_queue import dltq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  // hold-off register: write it only while idle (the block does not enforce this)
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // front end: classify and queue
  dltq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid)
  );

  // back end: list walks, expiry, result word
  dltq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* sv/dltq_checker.sv */
// Port-level checks for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg and delta_list_timer_queue_macros.svh.
`include "delta_list_timer_queue_macros.svh"

module dltq_checker import dltq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  `DLTQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled word changed")
  `DLTQ_ASSERT_NOW(a_pool_range, out_valid, out_word.free_entries <= FULL_POOL, "pool count too large")
  `DLTQ_ASSERT_NOW(a_low_mark, out_valid, out_word.min_free_entries <= out_word.free_entries, "low mark above level")
  `DLTQ_ASSERT_NOW(a_fire_not_last, out_valid && out_word.kind == KIND_FIRE, !out_word.last, "fire marked last")
  `DLTQ_ASSERT_NOW(a_ack_last, out_valid && out_word.kind != KIND_FIRE, out_word.last, "ack not marked last")

endmodule

bind delta_list_timer_queue dltq_checker u_chk (.*);

/* sim/delta_list_timer_queue_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for delta_list_timer_queue: directed and random words,
// checked against an in-bench delta-list predictor. Depends on dltq_pkg and the RTL.
module delta_list_timer_queue_tb;
  import dltq_pkg::*;

  localparam int NIL_IX      = ENTRY_COUNT;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 300;   // random words; directed tests add about sixty

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  delta_list_timer_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the timer list and the free pool
  // ---------------------------------------------------------------------------
  logic [7:0]  tl_action[ENTRY_COUNT];
  logic [31:0] tl_delta[ENTRY_COUNT];
  logic        tl_asap[ENTRY_COUNT];
  int          tl_link[ENTRY_COUNT];
  int          tl_head;
  int          pool_head;
  int          pool_count;
  int          pool_low;
  logic [31:0] since_load;   // ticks since the last timer load
  logic [7:0]  gap_ticks;    // hold-off shadow

  out_word_t pending_results[$];   // words still owed by the block
  out_word_t word_batch[$];        // results of the word being predicted
  int        mismatches = 0;
  int        cycles = 0;
  int        burst_left = 0;
  bit        sender_gaps = 1'b1;

  function automatic longint as_signed(logic [31:0] x);
    return longint'($signed(x));
  endfunction

  function automatic void note_result(logic [1:0] kind, logic [7:0] act, logic run,
                                      logic late, logic [1:0] err);
    out_word_t r;
    r.kind             = kind;
    r.fired_action     = act;
    r.run_now          = run;
    r.overdue          = late;
    r.error_code       = err;
    r.free_entries     = CNT_W'(pool_count);
    r.min_free_entries = CNT_W'(pool_low);
    r.last             = 1'b0;
    word_batch.push_back(r);
  endfunction

  function automatic void pool_return(int i);
    tl_link[i] = pool_head;
    pool_head  = i;
    pool_count++;
  endfunction

  function automatic void timer_reset();
    for (int i = 0; i < ENTRY_COUNT; i++) tl_link[i] = i + 1;
    tl_head    = NIL_IX;
    pool_head  = 0;
    pool_count = ENTRY_COUNT;
    pool_low   = ENTRY_COUNT;
    since_load = '0;
    gap_ticks  = HOLD_OFF_RST;
  endfunction

  // unlink a pending action, folding its delta into the successor
  function automatic void unlink_action(logic [7:0] act);
    int prv, cur, nx, n;
    prv = NIL_IX;
    cur = tl_head;
    n   = 0;
    while (cur < ENTRY_COUNT && n < ENTRY_COUNT) begin
      if (tl_action[cur] == act) begin
        nx = tl_link[cur];
        if (prv == NIL_IX) tl_head = nx;
        else tl_link[prv] = nx;
        if (nx < ENTRY_COUNT) tl_delta[nx] = tl_delta[nx] + tl_delta[cur];
        pool_return(cur);
        return;
      end
      prv = cur;
      cur = tl_link[cur];
      n++;
    end
  endfunction

  function automatic void insert_timer(int i, logic [31:0] t);
    longint target, accum, nabs;
    int prv, cur, n;
    logic [31:0] d, load;
    target = longint'(t) + as_signed(since_load);
    accum  = 0;
    prv    = NIL_IX;
    n      = 0;
    unlink_action(tl_action[i]);
    cur = tl_head;
    while (cur < ENTRY_COUNT && n < ENTRY_COUNT) begin
      nabs = accum + longint'(tl_delta[cur]);
      if (nabs > target) break;
      accum = nabs;
      prv   = cur;
      cur   = tl_link[cur];
      n++;
    end
    d           = 32'(target - accum);
    tl_delta[i] = d;
    tl_link[i]  = cur;
    if (cur < ENTRY_COUNT) tl_delta[cur] = tl_delta[cur] - d;
    if (prv == NIL_IX) begin
      load = 32'(longint'(d) - as_signed(since_load));
      if (load < {24'd0, gap_ticks}) load = {24'd0, gap_ticks};
      tl_delta[i] = load;
      tl_head     = i;
      since_load  = '0;
    end else begin
      tl_link[prv] = i;
    end
  endfunction

  function automatic void advance_tick();
    int n, i;
    longint e, d;
    logic late;
    n = 0;
    since_load = since_load + 1;
    if (tl_head >= ENTRY_COUNT || as_signed(since_load) < longint'(tl_delta[tl_head])) return;
    while (tl_head < ENTRY_COUNT && n < ENTRY_COUNT) begin
      e = as_signed(since_load);
      d = longint'(tl_delta[tl_head]);
      if (e + longint'(gap_ticks) < d) begin
        tl_delta[tl_head] = 32'(d - e);
        since_load = '0;
        break;
      end
      late       = (e > d);
      since_load = 32'(e - d);
      i          = tl_head;
      tl_head    = tl_link[i];
      tl_link[i] = NIL_IX;
      pool_return(i);
      note_result(KIND_FIRE, tl_action[i], tl_asap[i], late, ERR_NONE);
      n++;
    end
  endfunction

  // expected results of one accepted word, queued in order
  function automatic void predict_word(in_word_t w);
    logic [1:0]  err;
    logic [31:0] t;
    logic        asap;
    int          i;
    err = ERR_NONE;
    t   = w.delay;
    word_batch.delete();
    if (w.operation == OP_TICK) begin
      advance_tick();
    end else if (w.operation == OP_CANCEL) begin
      if (w.action_id != 0) unlink_action(w.action_id);
    end else begin
      asap = (w.operation == OP_ASAP);
      if (asap && t == 0) begin
        err = ERR_ASAP;
      end else if (w.action_id != 0) begin
        if (t == 0 || t[31]) begin
          note_result(KIND_FIRE, w.action_id, asap, 1'b0, ERR_NONE);
        end else if (pool_head >= ENTRY_COUNT) begin
          err = ERR_POOL;
        end else begin
          i          = pool_head;
          pool_head  = tl_link[i];
          tl_link[i] = NIL_IX;
          pool_count--;
          if (pool_count < pool_low) pool_low = pool_count;
          tl_action[i] = w.action_id;
          tl_asap[i]   = asap;
          insert_timer(i, t);
        end
      end
    end
    note_result((err != ERR_NONE) ? KIND_ERR : KIND_ACK, 8'd0, 1'b0, 1'b0, err);
    word_batch[word_batch.size() - 1].last = 1'b1;
    foreach (word_batch[k]) pending_results.push_back(word_batch[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %p", out_word);
      end else begin
        exp_w = pending_results.pop_front();
        if (out_word.kind != exp_w.kind || out_word.fired_action != exp_w.fired_action ||
            out_word.run_now != exp_w.run_now || out_word.overdue != exp_w.overdue ||
            out_word.error_code != exp_w.error_code ||
            out_word.free_entries != exp_w.free_entries ||
            out_word.min_free_entries != exp_w.min_free_entries ||
            out_word.last != exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_w, out_word);
        end
      end
    end
  end

  // receiver stall: the mode steps through four patterns as the cycle count grows, including stall-free spells
  always @(posedge clk) begin
    int mode;
    mode = (cycles >> 8) % 4;
    case (mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= (cycles % 7) < 3;
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("delta_list_timer_queue regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (sender_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_word(input logic [1:0] op, input logic [7:0] act,
                           input logic [31:0] dly);
    in_word_t w;
    w.operation = op;
    w.action_id = act;
    w.delay     = dly;
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
    pace_sender();
  endtask

  // hold off until every owed result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);   // margin only: the sequencer is idle once the last result is back
  endtask

  task automatic set_hold_off(input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gap_ticks = v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_immediate_and_errors();
    send_word(OP_ASAP,   8'd0,   32'd0);          // asap zero delay, no action
    send_word(OP_ASAP,   8'd255, 32'd0);          // asap zero delay
    send_word(OP_DEFER,  8'd0,   32'd5);          // action zero ignored
    send_word(OP_CANCEL, 8'd0,   32'hFFFF_FFFF);
    send_word(OP_CANCEL, 8'd7,   32'd0);          // not pending
    send_word(OP_DEFER,  8'd255, 32'd0);          // fires at once
    send_word(OP_ASAP,   8'd1,   32'h8000_0000);  // most negative
    send_word(OP_DEFER,  8'd2,   32'hFFFF_FFFF);
    send_word(OP_ASAP,   8'd3,   32'h7FFF_FFFF);  // furthest deadline
    send_word(OP_CANCEL, 8'd3,   32'd0);
    send_word(OP_DEFER,  8'd4,   32'd3);
    send_word(OP_DEFER,  8'd4,   32'd1);          // duplicate replaced
    send_word(OP_ASAP,   8'd5,   32'd6);
    repeat (8) send_word(OP_TICK, 8'hAA, 32'h5555_AAAA);
  endtask

  task automatic test_pool_exhaustion();
    set_hold_off(8'd0);
    for (int k = 0; k < ENTRY_COUNT; k++)
      send_word(OP_DEFER, 8'(16 + k), 32'(k + 1));
    send_word(OP_DEFER, 8'd99, 32'd4);   // pool empty
    send_word(OP_DEFER, 8'd16, 32'd9);   // pool empty, duplicate kept
    repeat (ENTRY_COUNT + 2) send_word(OP_TICK, 8'd0, 32'd0);
  endtask

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 32'($urandom_range(1, 40));
    if (r < 78) return 32'($urandom_range(1, 3000));
    if (r < 87) return $urandom | 32'h8000_0000;
    if (r < 93) return 32'd0;
    return $urandom & 32'h7FFF_FFFF;
  endfunction

  task automatic random_phase(input int count);
    int r;
    logic [1:0] op;
    logic [7:0] act;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_TICK;
      else if (r < 72) op = OP_DEFER;
      else if (r < 87) op = OP_ASAP;
      else op = OP_CANCEL;
      r = $urandom_range(0, 99);
      if (r < 80) act = 8'($urandom_range(1, 20));
      else if (r < 88) act = 8'd0;
      else act = 8'($urandom);
      send_word(op, act, pick_delay());
      if (n % 50 == 49) drain();
    end
  endtask

  task automatic test_random_settings();
    int per;
    per = ITEM_TARGET / 4;
    sender_gaps = 1'b0;          // back-to-back spell
    set_hold_off(8'd255);
    random_phase(per);
    sender_gaps = 1'b1;
    set_hold_off(8'd0);
    random_phase(per);
    set_hold_off(8'($urandom_range(1, 12)));
    random_phase(per);
    set_hold_off(HOLD_OFF_RST);
    random_phase(per);
  endtask

  initial begin
    timer_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_immediate_and_errors();
    test_pool_exhaustion();
    test_random_settings();
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("delta_list_timer_queue regression: pass");
    end else begin
      $display("delta_list_timer_queue regression: fail");
    end
    $finish;
  end

endmodule

/* delta_list_timer_queue.f */
+incdir+sv
sv/dltq_pkg.sv
sv/dltq_front.sv
sv/dltq_back.sv
sv/delta_list_timer_queue.sv
sv/dltq_checker.sv
sim/delta_list_timer_queue_tb.sv
